@@ rtl/ipv4lpm_pkg.sv @@
// Shared types, constants and helpers for the IPv4 longest-prefix-match route table.
package ipv4lpm_pkg;

	localparam int DEF_ENTRIES = 64;

	localparam logic       MODE_INSERT = 1'b0;
	localparam logic       MODE_LOOKUP = 1'b1;
	localparam logic [5:0] PREFIX_MAX  = 6'd32;

	typedef struct packed {
		logic        mode;
		logic [31:0] address;
		logic [5:0]  prefix_length;
		logic [31:0] table_number;
		logic [31:0] source_address;
		logic [31:0] gateway_address;
		logic [15:0] path_mtu;
		logic        link_up;
	} req_t;

	typedef struct packed {
		logic        match_found;
		logic [31:0] result_source;
		logic [31:0] result_gateway;
		logic [15:0] result_mtu;
		logic        table_full;
	} rsp_t;

	// one stored route
	typedef struct packed {
		logic [31:0] dest;
		logic [5:0]  prefix;
		logic [31:0] table_num;
		logic [31:0] source;
		logic [31:0] gateway;
		logic [15:0] mtu;
		logic        link_up;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // latch request, clear result and scan pointer
		logic write;  // append latched route (or flag full)
		logic rd_en;  // read entry at scan pointer, advance pointer
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;      // no stored entries
		logic scan_last;  // scan pointer sits on the last stored entry
	} status_t;

	// top len bits set; len of 32 or more gives all ones
	function automatic logic [31:0] prefix_mask(input logic [5:0] len);
		prefix_mask = ~(32'hFFFF_FFFF >> len);
	endfunction

endpackage

@@ rtl/ipv4lpm_ctrl.sv @@
// Sequencer for insert and lookup transactions of the route table.
module ipv4lpm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  mode,
	input  ipv4lpm_pkg::status_t  status,
	output ipv4lpm_pkg::cmd_t     cmd,
	output logic                  busy,
	output logic                  done
);
	import ipv4lpm_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_INSERT = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_RESP   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (mode == MODE_INSERT)
						state_nxt = ST_INSERT;
					else if (status.empty)
						state_nxt = ST_RESP;
					else
						state_nxt = ST_SCAN;
				end
			end
			ST_INSERT: begin
				cmd.write = 1'b1;
				state_nxt = ST_RESP;
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (status.scan_last)
					state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				// last read entry is compared during this cycle
				state_nxt = ST_RESP;
			end
			ST_RESP: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESP);

endmodule

@@ rtl/ipv4lpm_datapath.sv @@
// Route storage, scan pointer, prefix compare and best-match registers.
module ipv4lpm_datapath #(
	parameter int ENTRIES = ipv4lpm_pkg::DEF_ENTRIES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipv4lpm_pkg::req_t     request,
	input  ipv4lpm_pkg::cmd_t     cmd,
	output ipv4lpm_pkg::status_t  status,
	output ipv4lpm_pkg::rsp_t     result
);
	import ipv4lpm_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	entry_t             mem [ENTRIES];
	req_t               req_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   rd_ptr_q;
	entry_t             rd_data_s1;
	logic               rd_v_s1;
	logic               found_q;
	logic               full_q;
	logic [5:0]         best_len_q;
	logic [31:0]        best_src_q;
	logic [31:0]        best_gw_q;
	logic [15:0]        best_mtu_q;
	logic               is_full;
	logic               hit;
	logic               take;
	entry_t             wr_entry;

	assign is_full = (count_q == CNT_W'(ENTRIES));

	always_comb begin
		wr_entry.dest      = req_q.address;
		wr_entry.prefix    = (req_q.prefix_length > PREFIX_MAX) ? PREFIX_MAX
		                                                        : req_q.prefix_length;
		wr_entry.table_num = req_q.table_number;
		wr_entry.source    = req_q.source_address;
		wr_entry.gateway   = req_q.gateway_address;
		wr_entry.mtu       = req_q.path_mtu;
		wr_entry.link_up   = req_q.link_up;
	end

	// route memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.write && !is_full)
			mem[count_q[IDX_W-1:0]] <= wr_entry;
		if (cmd.rd_en)
			rd_data_s1 <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			req_q <= request;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_ptr_q <= '0;
			rd_v_s1  <= 1'b0;
			full_q   <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.rd_en;
			if (cmd.load) begin
				rd_ptr_q <= '0;
				full_q   <= 1'b0;
			end else if (cmd.rd_en) begin
				rd_ptr_q <= rd_ptr_q + IDX_W'(1);
			end
			if (cmd.write) begin
				if (is_full)
					full_q <= 1'b1;
				else
					count_q <= count_q + CNT_W'(1);
			end
		end
	end

	assign status.empty     = (count_q == '0);
	assign status.scan_last = ((CNT_W'(rd_ptr_q) + CNT_W'(1)) == count_q);

	// entry qualifies: link up, same table, destination agrees under its mask
	assign hit = rd_data_s1.link_up
	          && (rd_data_s1.table_num == req_q.table_number)
	          && (((rd_data_s1.dest ^ req_q.address) & prefix_mask(rd_data_s1.prefix))
	              == 32'd0);
	// strictly longer replaces, so the earliest entry wins a tie
	assign take = rd_v_s1 && hit && (!found_q || (rd_data_s1.prefix > best_len_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			found_q <= 1'b0;
		else if (cmd.load)
			found_q <= 1'b0;
		else if (take)
			found_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			best_len_q <= '0;
			best_src_q <= '0;
			best_gw_q  <= '0;
			best_mtu_q <= '0;
		end else if (take) begin
			best_len_q <= rd_data_s1.prefix;
			best_src_q <= rd_data_s1.source;
			best_gw_q  <= rd_data_s1.gateway;
			best_mtu_q <= rd_data_s1.mtu;
		end
	end

	assign result.match_found    = found_q;
	assign result.result_source  = best_src_q;
	assign result.result_gateway = best_gw_q;
	assign result.result_mtu     = best_mtu_q;
	assign result.table_full     = full_q;

endmodule

@@ rtl/ipv4_route_longest_prefix_match.sv @@
// Top level of the IPv4 longest-prefix-match route table.
//
//  channel   handshake        payload              direction
//  --------  ---------------  -------------------  ---------
//  request   start / busy     request (req_t)      in
//  result    done (strobe)    result  (rsp_t)      out
//
// A transaction is accepted on a rising edge with start high and busy low.
// Insert: the route is appended (or the table flagged full) in the insert state,
// then the result strobe (done) comes in the response state. Lookup: the scan
// reads one route per cycle through the single read port of the route memory,
// then a drain state compares the last route read and a response state gives
// the result. An empty table skips the scan and goes straight to the response state.
// Reset clears the route count and the sequencer; route memory is not cleared.
// done is high for exactly one cycle; the receiver cannot stall it.
module ipv4_route_longest_prefix_match #(
	parameter int ENTRIES = ipv4lpm_pkg::DEF_ENTRIES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ipv4lpm_pkg::req_t  request,
	output logic               done,
	output ipv4lpm_pkg::rsp_t  result
);
	import ipv4lpm_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer: idle -> insert or scan/drain (skipped on an empty table) -> response
	ipv4lpm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (request.mode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// route memory and match logic; result fields are held in registers
	ipv4lpm_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.status  (status),
		.result  (result)
	);

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the IPv4 longest-prefix-match route table.
module testbench;
	import ipv4lpm_pkg::*;

	localparam int ROUTE_SLOTS = DEF_ENTRIES;
	// slowest lookup scans every slot; the limit also covers the longest sender gap
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int RANDOM_ITEMS = 1930;

	typedef struct {
		req_t req;
		bit   typed;
		rsp_t answer;
	} drill_row_t;

	typedef struct {
		bit   typed;
		rsp_t answer;
	} typed_note_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t request;
	rsp_t result;

	// shadow route table, updated as each transaction is accepted
	entry_t rt_store [ROUTE_SLOTS];
	int     rt_count;

	rsp_t        pending_results [$];
	typed_note_t typed_answers [$];
	drill_row_t  drill [$];
	int          mismatch_count;
	int          cycle_count;

	ipv4_route_longest_prefix_match #(.ENTRIES(ROUTE_SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** ipv4_route_longest_prefix_match: FAILED **");
			$finish;
		end
	end

	// top len bits set; anything from 32 up is a host route
	function automatic logic [31:0] net_mask(input logic [5:0] len);
		if (len == 6'd0)
			return 32'h0;
		if (len >= PREFIX_MAX)
			return 32'hFFFF_FFFF;
		return 32'hFFFF_FFFF << (6'd32 - len);
	endfunction

	// Predicts the answer to one transaction and applies its effect on the
	// shadow table. Inserts append or report full; lookups pick the longest
	// matching prefix among up routes of the same table, earliest on a tie.
	function automatic rsp_t predict_answer(input req_t r);
		rsp_t   ans;
		bit     hit;
		int     best;
		entry_t e;

		ans  = '0;
		hit  = 1'b0;
		best = 0;
		if (r.mode == MODE_INSERT) begin
			if (rt_count >= ROUTE_SLOTS) begin
				ans.table_full = 1'b1;
				return ans;
			end
			e.dest      = r.address;
			e.prefix    = (r.prefix_length > PREFIX_MAX) ? PREFIX_MAX : r.prefix_length;
			e.table_num = r.table_number;
			e.source    = r.source_address;
			e.gateway   = r.gateway_address;
			e.mtu       = r.path_mtu;
			e.link_up   = r.link_up;
			rt_store[rt_count] = e;
			rt_count++;
			return ans;
		end
		for (int i = 0; i < rt_count; i++) begin
			e = rt_store[i];
			if (!e.link_up || e.table_num != r.table_number)
				continue;
			if (((e.dest ^ r.address) & net_mask(e.prefix)) != 32'h0)
				continue;
			// strict greater keeps the earliest route on equal length
			if (!hit || e.prefix > rt_store[best].prefix) begin
				hit  = 1'b1;
				best = i;
			end
		end
		if (hit) begin
			ans.match_found    = 1'b1;
			ans.result_source  = rt_store[best].source;
			ans.result_gateway = rt_store[best].gateway;
			ans.result_mtu     = rt_store[best].mtu;
		end
		return ans;
	endfunction

	task automatic report_mismatch(input string what, input rsp_t want, input rsp_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$write("mismatch (%s): want found=%b src=%h gw=%h mtu=%h full=%b, ",
				what, want.match_found, want.result_source, want.result_gateway,
				want.result_mtu, want.table_full);
			$display("got found=%b src=%h gw=%h mtu=%h full=%b",
				got.match_found, got.result_source, got.result_gateway,
				got.result_mtu, got.table_full);
		end
	endtask

	// Result side: check a strobed result first, then book the transaction
	// accepted at this edge. The typed-answer note for a transaction is queued
	// by the sender before it raises start, so it is always there by now.
	always @(posedge clk) begin
		rsp_t        want;
		rsp_t        pred;
		typed_note_t note;

		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", '0, result);
				end else begin
					want = pending_results.pop_front();
					if (result.match_found !== want.match_found ||
					    result.result_source !== want.result_source ||
					    result.result_gateway !== want.result_gateway ||
					    result.result_mtu !== want.result_mtu ||
					    result.table_full !== want.table_full)
						report_mismatch("field", want, result);
				end
			end
			if (start && !busy) begin
				pred = predict_answer(request);
				note = typed_answers.pop_front();
				pending_results.insert(pending_results.size(),
					note.typed ? note.answer : pred);
			end
		end
	end

	function automatic req_t mk_req(input logic mode, input logic [31:0] addr,
			input logic [5:0] plen, input logic [31:0] tbl, input logic [31:0] src,
			input logic [31:0] gw, input logic [15:0] mtu, input logic up);
		req_t r;

		r.mode            = mode;
		r.address         = addr;
		r.prefix_length   = plen;
		r.table_number    = tbl;
		r.source_address  = src;
		r.gateway_address = gw;
		r.path_mtu        = mtu;
		r.link_up         = up;
		return r;
	endfunction

	function automatic logic [31:0] pick_table();
		case ($urandom_range(0, 6))
			0, 1:    return 32'h0;
			2, 3:    return 32'hFFFF_FFFF;
			4:       return 32'h1;
			5:       return 32'h0000_00FE;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [5:0] pick_prefix();
		int roll;

		roll = $urandom_range(0, 99);
		if (roll < 8)
			return 6'd0;
		if (roll < 18)
			return 6'd32;
		if (roll < 24)
			return 6'($urandom_range(33, 63));
		return 6'($urandom_range(1, 31));
	endfunction

	// Once routes are stored, half of the inserts nest under or duplicate them so that
	// lookups see competing prefixes and equal-length ties.
	function automatic req_t make_insert();
		req_t   r;
		entry_t base;
		int     roll;

		r      = mk_req(MODE_INSERT, $urandom, pick_prefix(), pick_table(), $urandom,
			$urandom, 16'($urandom), ($urandom_range(0, 99) < 80));
		roll   = $urandom_range(0, 99);
		if (rt_count > 0 && roll < 50) begin
			base = rt_store[$urandom_range(0, rt_count - 1)];
			if (roll < 12) begin
				r.address       = base.dest;
				r.prefix_length = base.prefix;
			end else begin
				r.address = (base.dest & net_mask(base.prefix)) |
					($urandom & ~net_mask(base.prefix));
			end
			if ($urandom_range(0, 9) < 8)
				r.table_number = base.table_num;
		end
		case ($urandom_range(0, 9))
			0: r.gateway_address = 32'h0;
			1: r.path_mtu = 16'hFFFF;
			2: r.path_mtu = 16'h0;
			default: ;
		endcase
		return r;
	endfunction

	function automatic req_t make_lookup();
		req_t   r;
		entry_t base;

		r = mk_req(MODE_LOOKUP, $urandom, 6'($urandom), pick_table(), $urandom,
			$urandom, 16'($urandom), 1'($urandom));
		if (rt_count > 0 && $urandom_range(0, 99) < 75) begin
			base      = rt_store[$urandom_range(0, rt_count - 1)];
			r.address = base.dest ^ ($urandom & ~net_mask(base.prefix));
			if ($urandom_range(0, 99) < 85)
				r.table_number = base.table_num;
		end
		return r;
	endfunction

	// Mostly back-to-back or short gaps, now and then a long one that lets
	// the block go fully idle.
	function automatic int pick_gap();
		int roll;

		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 90);
	endfunction

	// Holds start and the request until the block takes the transaction;
	// start is left high so a follow-on transaction needs no extra edge.
	task automatic issue(input req_t r, input bit typed, input rsp_t answer);
		typed_note_t note;

		note.typed  = typed;
		note.answer = answer;
		typed_answers.insert(typed_answers.size(), note);
		request <= r;
		start   <= 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic pause(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// one edge first so the transaction accepted at the current edge is booked
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic add_row(input req_t r, input bit typed);
		drill_row_t row;

		row.req    = r;
		row.typed  = typed;
		row.answer = '0;
		drill.insert(drill.size(), row);
	endtask

	initial begin
		req_t r;
		bit   full;
		int   quiet;

		arst_n         = 1'b0;
		start          = 1'b0;
		request        = '0;
		rt_count       = 0;
		mismatch_count = 0;
		cycle_count    = 0;

		// Directed rows. Typed answers are all-zero ones: lookups on an empty
		// table or with no usable route, and inserts that still fit.
		add_row(mk_req(MODE_LOOKUP, 32'h0, 6'd0, 32'h0, '0, '0, '0, 1'b0), 1'b1);
		add_row(mk_req(MODE_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, '1, '1, '1, 1'b1),
			1'b1);
		// default route
		add_row(mk_req(MODE_INSERT, 32'h0, 6'd0, 32'h0, 32'h0A00_00FE, 32'hC0A8_0001,
			16'd1500, 1'b1), 1'b1);
		// host route at the top of the address space, all-ones fields
		add_row(mk_req(MODE_INSERT, 32'hFFFF_FFFF, 6'd32, 32'h0, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 16'hFFFF, 1'b1), 1'b1);
		// prefix length past 32 is stored as a host route
		add_row(mk_req(MODE_INSERT, 32'h0A00_0001, 6'd63, 32'h0, 32'h0A00_0001, 32'h0,
			16'd9000, 1'b1), 1'b1);
		// same /8 three times: link down, then two up; first up one must win
		add_row(mk_req(MODE_INSERT, 32'h0A00_0000, 6'd8, 32'h0, 32'h1111_1111,
			32'h0A00_0001, 16'd1500, 1'b0), 1'b1);
		add_row(mk_req(MODE_INSERT, 32'h0A00_0000, 6'd8, 32'h0, 32'h2222_2222,
			32'h0A00_00FE, 16'd1400, 1'b1), 1'b1);
		add_row(mk_req(MODE_INSERT, 32'h0A00_0000, 6'd8, 32'h0, 32'h3333_3333,
			32'h0A00_00FD, 16'd1300, 1'b1), 1'b1);
		add_row(mk_req(MODE_INSERT, 32'h0A01_0000, 6'd16, 32'hFFFF_FFFF, 32'h4444_4444,
			32'h0, 16'h0, 1'b1), 1'b1);
		add_row(mk_req(MODE_INSERT, 32'hC0A8_0100, 6'd24, 32'h1, 32'h5555_5555,
			32'hC0A8_0101, 16'd576, 1'b0), 1'b1);
		add_row(mk_req(MODE_LOOKUP, 32'h0A00_0001, 6'd0, 32'h0, '0, '0, '0, 1'b0), 1'b0);
		add_row(mk_req(MODE_LOOKUP, 32'h0A02_0304, 6'd0, 32'h0, '0, '0, '0, 1'b0), 1'b0);
		add_row(mk_req(MODE_LOOKUP, 32'h0B00_0000, 6'd0, 32'h0, '0, '0, '0, 1'b0), 1'b0);
		add_row(mk_req(MODE_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, '0, '0, '0, 1'b0), 1'b0);
		add_row(mk_req(MODE_LOOKUP, 32'h0A01_FFFF, 6'd0, 32'hFFFF_FFFF, '0, '0, '0, 1'b0),
			1'b0);
		// no route in this table covers the key
		add_row(mk_req(MODE_LOOKUP, 32'h0B00_0000, 6'd0, 32'hFFFF_FFFF, '0, '0, '0, 1'b0),
			1'b1);
		// only a link-down route covers it
		add_row(mk_req(MODE_LOOKUP, 32'hC0A8_0101, 6'd0, 32'h1, '0, '0, '0, 1'b0), 1'b1);
		// table that holds nothing
		add_row(mk_req(MODE_LOOKUP, 32'h0A00_0000, 6'd0, 32'h5, '0, '0, '0, 1'b0), 1'b1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (drill[i]) begin
			issue(drill[i].req, drill[i].typed, drill[i].answer);
			pause(pick_gap());
		end
		drain();

		// Random part: fills the table with nested and duplicate routes, then
		// keeps looking up with an occasional insert that must be refused.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			full  = (rt_count >= ROUTE_SLOTS);
			r     = ($urandom_range(0, 99) < (full ? 6 : 35)) ? make_insert() : make_lookup();
			issue(r, 1'b0, '0);
			quiet = ((n / 50) % 4 == 3);
			if (n % 400 == 399)
				drain();
			else if (!quiet)
				pause(pick_gap());
		end

		drain();
		// a stray strobe would show up within one full scan
		repeat (ROUTE_SLOTS + 8) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("** ipv4_route_longest_prefix_match: PASSED **");
		else
			$display("** ipv4_route_longest_prefix_match: FAILED **");
		$finish;
	end

endmodule
